// ----- design/lpbc_pkg.sv -----
package lpbc_pkg;

  localparam int ColorW = 15;
  localparam int ChanW  = 5;
  localparam int ProdW  = 2 * ChanW;
  localparam int LayerW = 3;
  localparam int PrioW  = 3;

  localparam logic [LayerW-1:0] LAYER_SPRITE   = 3'd4;
  localparam logic [LayerW-1:0] LAYER_BACKDROP = 3'd5;
  localparam logic [PrioW-1:0]  PRIO_BACKDROP  = 3'd4;

  localparam logic [ChanW-1:0] CHAN_MAX   = 5'h1F;
  localparam logic [4:0]       WEIGHT_MAX = 5'd16;

  localparam logic [2:0] REG_DISPLAY_CONTROL   = 3'd0;
  localparam logic [2:0] REG_BG_PRIORITIES     = 3'd1;
  localparam logic [2:0] REG_BLEND_CONTROL     = 3'd2;
  localparam logic [2:0] REG_ALPHA_WEIGHTS     = 3'd3;
  localparam logic [2:0] REG_BRIGHTNESS_WEIGHT = 3'd4;
  localparam logic [2:0] REG_BACKDROP_COLOR    = 3'd5;

  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_ALPHA    = 2'd1;
  localparam logic [1:0] MODE_BRIGHTEN = 2'd2;
  localparam logic [1:0] MODE_DARKEN   = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ALPHA,
    OP_BRIGHTEN,
    OP_DARKEN
  } blend_op_t;

  typedef struct packed {
    logic [ColorW-1:0] top_c;
    logic [ColorW-1:0] sec_c;
    logic [LayerW-1:0] top_l;
    logic [LayerW-1:0] sec_l;
  } layer_sel_t;

  function automatic logic [4:0] clamp16(input logic [4:0] w);
    return (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
  endfunction

endpackage

// ----- design/lpbc_layer_sel.sv -----
module lpbc_layer_sel
  import lpbc_pkg::*;
(
  input  logic [ColorW-1:0] bg_color [4],
  input  logic [3:0]        bg_valid,
  input  logic [ColorW-1:0] sprite_color,
  input  logic [1:0]        sprite_priority,
  input  logic              sprite_valid,
  input  logic [5:0]        display_control,
  input  logic [7:0]        bg_priorities,
  input  logic [ColorW-1:0] backdrop_color,
  output layer_sel_t        sel
);

  always_comb begin
    logic [PrioW-1:0] top_p;
    logic [PrioW-1:0] sec_p;
    logic [PrioW-1:0] p;
    sel.top_c = backdrop_color;
    sel.sec_c = backdrop_color;
    sel.top_l = LAYER_BACKDROP;
    sel.sec_l = LAYER_BACKDROP;
    top_p = PRIO_BACKDROP;
    sec_p = PRIO_BACKDROP;
    // Backgrounds in ascending order, so a strict compare keeps the lower one on ties.
    for (int b = 0; b < 4; b++) begin
      p = {1'b0, bg_priorities[2*b +: 2]};
      if (display_control[b] && bg_valid[b]) begin
        if (p < top_p) begin
          sel.sec_c = sel.top_c;
          sel.sec_l = sel.top_l;
          sec_p = top_p;
          sel.top_c = bg_color[b];
          sel.top_l = LayerW'(b);
          top_p = p;
        end else if (p < sec_p) begin
          sel.sec_c = bg_color[b];
          sel.sec_l = LayerW'(b);
          sec_p = p;
        end
      end
    end
    // The sprite wins ties against any background.
    p = {1'b0, sprite_priority};
    if (display_control[4] && sprite_valid) begin
      if (p <= top_p) begin
        sel.sec_c = sel.top_c;
        sel.sec_l = sel.top_l;
        sel.top_c = sprite_color;
        sel.top_l = LAYER_SPRITE;
      end else if (p <= sec_p) begin
        sel.sec_c = sprite_color;
        sel.sec_l = LAYER_SPRITE;
      end
    end
  end

endmodule

// ----- design/layer_priority_blend_compositor.sv -----
// Layer priority compositor with color blending, one screen pixel per transaction.
//
// Input channel (in_*): four background colors with opaque bits and one sprite
// pixel with priority, valid and semi-transparent flags, all BGR555. Result
// channel (out_*): one RGB888 pixel per input transaction, in order.
// Configuration (cfg_*): registers are written through cfg_wr_en, cfg_index
// and cfg_wdata while no pixel is in flight.
//
// The pipeline has three register stages: layer selection, blend decision
// with the per-channel weight products, and sum, saturate and format into the
// output register, whose valid bit drives out_valid. One pixel is taken every
// cycle when the receiver does not stall.
// Each stage holds while the stage after it is full and blocked, so a stall on
// the result channel backs up into in_stall only once all stages are full;
// nothing is dropped or repeated. Reset empties the pipeline and clears every
// configuration register to zero. Forced blank yields white pixels.
module layer_priority_blend_compositor
  import lpbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ColorW-1:0] in_bg0_color,
  input  logic [ColorW-1:0] in_bg1_color,
  input  logic [ColorW-1:0] in_bg2_color,
  input  logic [ColorW-1:0] in_bg3_color,
  input  logic [3:0]        in_bg_valid,
  input  logic [ColorW-1:0] in_sprite_color,
  input  logic [1:0]        in_sprite_priority,
  input  logic              in_sprite_valid,
  input  logic              in_sprite_semi_transparent,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [14:0]       cfg_wdata
);

  logic [5:0]        display_control_r;
  logic [7:0]        bg_priorities_r;
  logic [13:0]       blend_control_r;
  logic [12:0]       alpha_weights_r;
  logic [4:0]        brightness_weight_r;
  logic [ColorW-1:0] backdrop_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_control_r   <= '0;
      bg_priorities_r     <= '0;
      blend_control_r     <= '0;
      alpha_weights_r     <= '0;
      brightness_weight_r <= '0;
      backdrop_color_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DISPLAY_CONTROL:   display_control_r   <= cfg_wdata[5:0];
        REG_BG_PRIORITIES:     bg_priorities_r     <= cfg_wdata[7:0];
        REG_BLEND_CONTROL:     blend_control_r     <= cfg_wdata[13:0];
        REG_ALPHA_WEIGHTS:     alpha_weights_r     <= cfg_wdata[12:0];
        REG_BRIGHTNESS_WEIGHT: brightness_weight_r <= cfg_wdata[4:0];
        REG_BACKDROP_COLOR:    backdrop_color_r    <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  logic [1:0] mode;
  logic [5:0] first_t;
  logic [5:0] second_t;
  logic [4:0] eva;
  logic [4:0] evb;
  logic [4:0] evy;

  assign mode     = blend_control_r[7:6];
  assign first_t  = blend_control_r[5:0];
  assign second_t = blend_control_r[13:8];
  assign eva      = clamp16(alpha_weights_r[4:0]);
  assign evb      = clamp16(alpha_weights_r[12:8]);
  assign evy      = clamp16(brightness_weight_r);

  // Stage handshake: a stage loads when it is empty or its contents move on.
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage 1: layer selection.
  logic [ColorW-1:0] bg_color [4];
  layer_sel_t        sel_nxt;
  layer_sel_t        sel_r;
  logic              semi_r;

  assign bg_color[0] = in_bg0_color;
  assign bg_color[1] = in_bg1_color;
  assign bg_color[2] = in_bg2_color;
  assign bg_color[3] = in_bg3_color;

  lpbc_layer_sel u_layer_sel (
    .bg_color        (bg_color),
    .bg_valid        (in_bg_valid),
    .sprite_color    (in_sprite_color),
    .sprite_priority (in_sprite_priority),
    .sprite_valid    (in_sprite_valid),
    .display_control (display_control_r),
    .bg_priorities   (bg_priorities_r),
    .backdrop_color  (backdrop_color_r),
    .sel             (sel_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sel_r  <= sel_nxt;
      semi_r <= in_sprite_semi_transparent;
    end
  end

  // Stage 2: blend decision and weight products.
  blend_op_t        op_nxt, op_r;
  logic [ChanW-1:0] ch_nxt [3];
  logic [ProdW-1:0] pa_nxt [3];
  logic [ProdW-1:0] pb_nxt [3];
  logic [ChanW-1:0] ch_r   [3];
  logic [ProdW-1:0] pa_r   [3];
  logic [ProdW-1:0] pb_r   [3];

  always_comb begin
    logic top_first;
    logic sec_second;
    logic [ChanW-1:0] c2;
    top_first  = first_t[sel_r.top_l];
    sec_second = second_t[sel_r.sec_l];
    // A semi-transparent sprite on top blends with any second target;
    // otherwise the mode decides as usual.
    priority if (sel_r.top_l == LAYER_SPRITE && semi_r && sec_second) begin
      op_nxt = OP_ALPHA;
    end else if (mode == MODE_ALPHA && top_first && sec_second) begin
      op_nxt = OP_ALPHA;
    end else if (mode == MODE_BRIGHTEN && top_first) begin
      op_nxt = OP_BRIGHTEN;
    end else if (mode == MODE_DARKEN && top_first) begin
      op_nxt = OP_DARKEN;
    end else begin
      op_nxt = OP_NONE;
    end
    for (int k = 0; k < 3; k++) begin
      ch_nxt[k] = sel_r.top_c[ChanW*k +: ChanW];
      c2        = sel_r.sec_c[ChanW*k +: ChanW];
      pb_nxt[k] = c2 * evb;
      unique case (op_nxt)
        OP_BRIGHTEN: pa_nxt[k] = (CHAN_MAX - ch_nxt[k]) * evy;
        OP_DARKEN:   pa_nxt[k] = ch_nxt[k] * evy;
        default:     pa_nxt[k] = ch_nxt[k] * eva;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      op_r <= op_nxt;
      ch_r <= ch_nxt;
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
  end

  // Stage 3: sum, saturate and format into the output register.
  logic [7:0] rgb_nxt [3];

  always_comb begin
    logic [ProdW:0]   sum;
    logic [ProdW-4:0] q;
    logic [ChanW-1:0] v;
    for (int k = 0; k < 3; k++) begin
      sum = {1'b0, pa_r[k]} + {1'b0, pb_r[k]};
      q   = sum[ProdW:4];
      unique case (op_r)
        OP_ALPHA:    v = (q > {2'b00, CHAN_MAX}) ? CHAN_MAX : q[ChanW-1:0];
        OP_BRIGHTEN: v = ch_r[k] + pa_r[k][ChanW+3:4];
        OP_DARKEN:   v = ch_r[k] - pa_r[k][ChanW+3:4];
        default:     v = ch_r[k];
      endcase
      rgb_nxt[k] = display_control_r[5] ? 8'hFF : {v, 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_red   <= rgb_nxt[0];
      out_green <= rgb_nxt[1];
      out_blue  <= rgb_nxt[2];
    end
  end

  assign out_valid = v3_r;

endmodule
